>>> hw/rtl/smf_pkg.sv
package smf_pkg;

   localparam int MAX_HALF_WIDTH = 7;
   localparam int SAMPLE_BITS    = 16;
   localparam int STORE_DEPTH    = 2 * MAX_HALF_WIDTH + 1;
   localparam int IDX_W          = $clog2(STORE_DEPTH);
   localparam int CNT_W          = $clog2(STORE_DEPTH + 1);
   localparam int HW_W           = 3;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [IDX_W-1:0]              idx_type;
   typedef logic [CNT_W-1:0]              cnt_type;
   typedef logic [HW_W-1:0]               hw_type;

   typedef sample_type window_type [STORE_DEPTH];

   typedef struct packed {
      sample_type sample;
      logic       frame_last;
   } req_type;

   typedef struct packed {
      sample_type filtered;
      logic       frame_end;
      logic       run_last;
   } rsp_type;

   // one median to compute: window is ages 0 .. last of the store
   typedef struct packed {
      idx_type last;
      logic    frame_end;
      logic    run_last;
   } job_type;

   function automatic idx_type count_ones(logic [STORE_DEPTH-1:0] bits);
      idx_type total;
      total = '0;
      for (int k = 0; k < STORE_DEPTH; k++) begin
         total = total + idx_type'(bits[k]);
      end
      return total;
   endfunction

endpackage

>>> hw/rtl/smf_median.sv
module smf_median (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  smf_pkg::job_type   job,
   input  smf_pkg::window_type window,
   output logic               job_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output smf_pkg::rsp_type   rsp_data
);
   import smf_pkg::*;

   // rank stage
   logic                   a_valid_ff;
   window_type             a_vals_ff;
   idx_type                a_rank_ff [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] a_win_ff;
   idx_type                a_lo_ff;
   idx_type                a_hi_ff;
   logic                   a_end_ff;
   logic                   a_rlast_ff;

   idx_type                rank_in [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] win_in;
   logic [STORE_DEPTH-1:0] below [STORE_DEPTH];

   // result stage
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   logic                   a_adv;
   logic                   b_adv;
   sample_type             lo_val;
   sample_type             hi_val;
   logic [SAMPLE_BITS:0]   pair_sum;

   assign b_adv     = !rsp_valid_ff || !rsp_stall;
   assign a_adv     = !a_valid_ff || b_adv;
   assign job_ready = a_adv;

   // rank of entry i = number of window entries ordered before it (ties by age)
   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         win_in[i] = idx_type'(i) <= job.last;
      end
      for (int i = 0; i < STORE_DEPTH; i++) begin
         for (int j = 0; j < STORE_DEPTH; j++) begin
            below[i][j] = win_in[j] && (j != i) &&
                          ((window[j] < window[i]) || ((window[j] == window[i]) && (j < i)));
         end
         rank_in[i] = count_ones(below[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_adv) begin
         a_valid_ff <= job_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv && job_valid) begin
         a_vals_ff  <= window;
         a_rank_ff  <= rank_in;
         a_win_ff   <= win_in;
         a_lo_ff    <= job.last >> 1;
         a_hi_ff    <= (job.last + idx_type'(1)) >> 1;
         a_end_ff   <= job.frame_end;
         a_rlast_ff <= job.run_last;
      end
   end

   // pick the two middle values; they coincide for an odd count
   always_comb begin
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (a_win_ff[i] && (a_rank_ff[i] == a_lo_ff)) begin
            lo_val = lo_val | a_vals_ff[i];
         end
         if (a_win_ff[i] && (a_rank_ff[i] == a_hi_ff)) begin
            hi_val = hi_val | a_vals_ff[i];
         end
      end
      pair_sum = {lo_val[SAMPLE_BITS-1], lo_val} + {hi_val[SAMPLE_BITS-1], hi_val};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (b_adv) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv && a_valid_ff) begin
         // floor of the mean: drop the low bit of the sign-extended sum
         rsp_data_ff.filtered  <= pair_sum[SAMPLE_BITS:1];
         rsp_data_ff.frame_end <= a_end_ff;
         rsp_data_ff.run_last  <= a_rlast_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/sliding_median_filter_core.sv
// Sliding median filter over frames of signed 16-bit samples.
// Input channel req_*: one sample per item, frame_last on the final sample.
// Result channel rsp_*: one filtered value per frame position, lagging the
// input by W positions (W = half width from csr_data, reset value 1).
// csr_* takes a new half width at any time csr_valid is high (always ready);
// write it only while the block is idle.
// Throughput: one sample per cycle while req_stall is low. A sample that is not the last of its
// frame yields at most one result, via the pending register, rank stage and result register.
// The last sample of a frame yields min(W, n-1)+1 results (n samples held,
// at most 15), one per cycle through the rank/select pipeline while rsp_stall allows; req_stall
// stays high until the last of them is issued, then the frame count clears.
// When rsp_stall is high the result register holds; the pending register and rank stage
// keep filling and req_stall rises only once a pending item cannot move.
// Synchronous reset empties the pipeline, clears the frame and sets W to 1.
module sliding_median_filter_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  smf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output smf_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  smf_pkg::hw_type  csr_data
);
   import smf_pkg::*;

   hw_type     half_width_ff;
   window_type store_ff;
   cnt_type    count_ff;
   cnt_type    count_in;
   logic       pend_ff;
   logic       pend_in;
   idx_type    pend_last_ff;
   idx_type    pend_last_in;
   logic       flush_ff;
   logic       flush_in;
   idx_type    d_ff;
   idx_type    d_in;
   idx_type    wl_ff;
   idx_type    wl_in;

   logic       req_acc;
   idx_type    w_eff;
   idx_type    two_w;
   cnt_type    count_new;
   idx_type    new_top;
   idx_type    last_single;
   idx_type    d_init;
   idx_type    flush_sum;
   idx_type    flush_top;
   idx_type    flush_last;

   logic       job_valid;
   job_type    job;
   logic       med_ready;
   logic       job_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff <= hw_type'(1);
      end else if (csr_valid) begin
         half_width_ff <= csr_data;
      end
   end

   assign w_eff = (int'(half_width_ff) > MAX_HALF_WIDTH) ? idx_type'(MAX_HALF_WIDTH)
                                                         : idx_type'(half_width_ff);
   assign two_w = w_eff << 1;

   assign req_acc   = req_valid && !req_stall;
   assign count_new = (count_ff == cnt_type'(STORE_DEPTH)) ? count_ff
                                                           : count_ff + cnt_type'(1);
   assign new_top     = idx_type'(count_new - cnt_type'(1));
   assign last_single = (two_w < new_top) ? two_w : new_top;
   assign d_init      = (w_eff < new_top) ? w_eff : new_top;

   assign flush_sum  = d_ff + wl_ff;
   assign flush_top  = idx_type'(count_ff - cnt_type'(1));
   assign flush_last = (flush_sum < flush_top) ? flush_sum : flush_top;

   assign job_valid     = pend_ff || flush_ff;
   assign job.last      = flush_ff ? flush_last : pend_last_ff;
   assign job.frame_end = flush_ff && (d_ff == '0);
   assign job.run_last  = !flush_ff || (d_ff == '0);
   assign job_take      = job_valid && med_ready;

   // hold input during a flush, or while a pending item cannot advance
   assign req_stall = flush_ff || (pend_ff && !med_ready);

   always_ff @(posedge clock) begin
      if (req_acc) begin
         store_ff[0] <= req_data.sample;
         for (int k = STORE_DEPTH - 1; k > 0; k--) begin
            store_ff[k] <= store_ff[k-1];
         end
      end
   end

   always_comb begin
      count_in     = count_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      flush_in     = flush_ff;
      d_in         = d_ff;
      wl_in        = wl_ff;
      if (job_take) begin
         if (flush_ff) begin
            if (d_ff == '0) begin
               flush_in = 1'b0;
               count_in = '0;
            end else begin
               d_in = d_ff - idx_type'(1);
            end
         end else begin
            pend_in = 1'b0;
         end
      end
      if (req_acc) begin
         count_in = count_new;
         if (!req_data.frame_last) begin
            pend_in      = count_new > cnt_type'(w_eff);
            pend_last_in = last_single;
         end else begin
            flush_in = 1'b1;
            d_in     = d_init;
            wl_in    = w_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
         flush_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
         flush_ff <= flush_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_last_ff <= pend_last_in;
      d_ff         <= d_in;
      wl_ff        <= wl_in;
   end

   smf_median u_median (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .window    (store_ff),
      .job_ready (med_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
